// ----- design/bts_pkg.sv -----
// Shared constants, control type and a size helper for the bilinear texture sampler.
package bts_pkg;

   localparam int DEF_MAX_WIDTH       = 256;
   localparam int DEF_MAX_HEIGHT      = 256;
   localparam int DEF_CHANNEL_BITS    = 16;
   localparam int DEF_COORD_FRAC_BITS = 16;

   localparam int SIZE_BITS  = 9;
   localparam int COORD_BITS = 17;
   localparam int POS_BITS   = 8;
   localparam int PORT_CH    = 16;

   localparam logic [SIZE_BITS-1:0] SIZE_RESET = 9'd256;

   typedef enum logic {
      REG_TEX_WIDTH  = 1'b0,
      REG_TEX_HEIGHT = 1'b1
   } csr_reg_type;

   typedef enum logic {
      FUNC_WRITE  = 1'b0,
      FUNC_SAMPLE = 1'b1
   } func_type;

   typedef struct packed {
      logic valid;
      logic sample;
      logic filt;
   } ctl_type;

   function automatic logic [SIZE_BITS-1:0] eff_size(input logic [SIZE_BITS-1:0] r,
                                                      input int maxv);
      logic [SIZE_BITS-1:0] s;
      if (r == '0) begin
         s = SIZE_BITS'(1);
      end else if (32'(r) > maxv) begin
         s = SIZE_BITS'(maxv);
      end else begin
         s = r;
      end
      return s;
   endfunction

endpackage

// ----- design/bts_coord.sv -----
// Input stage and coordinate mapping: texel index, neighbour and fraction per axis.
module bts_coord #(
   parameter int MAX_WIDTH       = 256,
   parameter int MAX_HEIGHT      = 256,
   parameter int CHANNEL_BITS    = 16,
   parameter int COORD_FRAC_BITS = 16,
   localparam int XW = $clog2(MAX_WIDTH),
   localparam int YW = $clog2(MAX_HEIGHT)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                func,
   input  logic [bts_pkg::POS_BITS-1:0]        column,
   input  logic [bts_pkg::POS_BITS-1:0]        row,
   input  logic [bts_pkg::PORT_CH-1:0]         red_in,
   input  logic [bts_pkg::PORT_CH-1:0]         green_in,
   input  logic [bts_pkg::PORT_CH-1:0]         blue_in,
   input  logic [bts_pkg::COORD_BITS-1:0]      coord_s,
   input  logic [bts_pkg::COORD_BITS-1:0]      coord_t,
   input  logic                                filtered,
   input  logic [bts_pkg::SIZE_BITS-1:0]       tex_width,
   input  logic [bts_pkg::SIZE_BITS-1:0]       tex_height,
   output bts_pkg::ctl_type                    ctl,
   output logic [XW-1:0]                       x0,
   output logic [XW-1:0]                       x1,
   output logic [YW-1:0]                       y0,
   output logic [YW-1:0]                       y1,
   output logic [COORD_FRAC_BITS:0]            fx,
   output logic [COORD_FRAC_BITS:0]            fy,
   output logic [3*CHANNEL_BITS-1:0]           wdata,
   output logic                                wr_ok
);
   import bts_pkg::*;

   localparam int F  = COORD_FRAC_BITS;
   localparam int PW = F + SIZE_BITS + 1;
   localparam logic [F:0] ONE = (F+1)'(1) << F;
   localparam logic [CHANNEL_BITS-1:0] CH_MAX = '1;

   logic                  v1_ff;
   logic                  func1_ff, filt1_ff;
   logic [POS_BITS-1:0]   col1_ff, row1_ff;
   logic [PORT_CH-1:0]    r1_ff, g1_ff, b1_ff;
   logic [COORD_BITS-1:0] s1_ff, t1_ff;

   ctl_type                  ctl_ff, ctl_in;
   logic [XW-1:0]            x0_ff, x0_in, x1_ff, x1_in;
   logic [YW-1:0]            y0_ff, y0_in, y1_ff, y1_in;
   logic [F:0]               fx_ff, fx_in, fy_ff, fy_in;
   logic [3*CHANNEL_BITS-1:0] wd_ff, wd_in;
   logic                     ok_ff, ok_in;

   logic [SIZE_BITS-1:0] wsz, hsz, ix, iy, ix1, iy1;
   logic [F:0]           fxm, fym;

   function automatic logic [CHANNEL_BITS-1:0] sat_in(input logic [PORT_CH-1:0] v);
      logic [CHANNEL_BITS-1:0] r;
      if (64'(v) > 64'(CH_MAX)) begin
         r = CH_MAX;
      end else begin
         r = CHANNEL_BITS'(v);
      end
      return r;
   endfunction

   function automatic logic [SIZE_BITS+F:0] map_c(input logic [COORD_BITS-1:0] c,
                                                 input logic [SIZE_BITS-1:0] sz);
      logic [F:0]           cc;
      logic [PW-1:0]        p;
      logic [SIZE_BITS:0]   ip;
      logic [SIZE_BITS-1:0] i;
      logic [F:0]           fr;
      cc = (64'(c) > 64'(ONE)) ? ONE : (F+1)'(c);
      p  = PW'(cc) * PW'(sz);
      ip = (SIZE_BITS+1)'(p >> F);
      if (ip >= {1'b0, sz}) begin
         i = sz - SIZE_BITS'(1);
      end else begin
         i = ip[SIZE_BITS-1:0];
      end
      fr = (F+1)'(p - (PW'(i) << F));
      return {i, fr};
   endfunction

   function automatic logic [SIZE_BITS-1:0] next_i(input logic [SIZE_BITS-1:0] i,
                                                  input logic [SIZE_BITS-1:0] sz);
      logic [SIZE_BITS-1:0] r;
      if (({1'b0, i} + (SIZE_BITS+1)'(1)) < {1'b0, sz}) begin
         r = i + SIZE_BITS'(1);
      end else begin
         r = sz - SIZE_BITS'(1);
      end
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start;
      end
      func1_ff <= func;
      filt1_ff <= filtered;
      col1_ff  <= column;
      row1_ff  <= row;
      r1_ff    <= red_in;
      g1_ff    <= green_in;
      b1_ff    <= blue_in;
      s1_ff    <= coord_s;
      t1_ff    <= coord_t;
   end

   always_comb begin
      wsz = eff_size(tex_width, MAX_WIDTH);
      hsz = eff_size(tex_height, MAX_HEIGHT);
      {ix, fxm} = map_c(s1_ff, wsz);
      {iy, fym} = map_c(t1_ff, hsz);
      ix1 = next_i(ix, wsz);
      iy1 = next_i(iy, hsz);

      ctl_in.valid  = v1_ff;
      ctl_in.sample = (func1_ff == FUNC_SAMPLE);
      ctl_in.filt   = filt1_ff;
      wd_in = {sat_in(b1_ff), sat_in(g1_ff), sat_in(r1_ff)};
      ok_in = v1_ff && (func1_ff == FUNC_WRITE) && (32'(col1_ff) < MAX_WIDTH)
              && (32'(row1_ff) < MAX_HEIGHT);
      fx_in = fxm;
      fy_in = fym;
      if (func1_ff == FUNC_SAMPLE) begin
         x0_in = XW'(ix);
         x1_in = XW'(ix1);
         y0_in = YW'(iy);
         y1_in = YW'(iy1);
      end else begin
         x0_in = XW'(col1_ff);
         x1_in = XW'(col1_ff);
         y0_in = YW'(row1_ff);
         y1_in = YW'(row1_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
         ok_ff  <= 1'b0;
      end else begin
         ctl_ff <= ctl_in;
         ok_ff  <= ok_in;
      end
      x0_ff <= x0_in;
      x1_ff <= x1_in;
      y0_ff <= y0_in;
      y1_ff <= y1_in;
      fx_ff <= fx_in;
      fy_ff <= fy_in;
      wd_ff <= wd_in;
   end

   assign ctl   = ctl_ff;
   assign x0    = x0_ff;
   assign x1    = x1_ff;
   assign y0    = y0_ff;
   assign y1    = y1_ff;
   assign fx    = fx_ff;
   assign fy    = fy_ff;
   assign wdata = wd_ff;
   assign wr_ok = ok_ff;

endmodule

// ----- design/bts_texmem.sv -----
// Four-bank texel store by column and row parity; each bank reads, may also write.
module bts_texmem #(
   parameter int MAX_WIDTH    = 256,
   parameter int MAX_HEIGHT   = 256,
   parameter int CHANNEL_BITS = 16,
   localparam int XW = $clog2(MAX_WIDTH),
   localparam int YW = $clog2(MAX_HEIGHT)
) (
   input  logic                      clock,
   input  logic [XW-1:0]             x0,
   input  logic [XW-1:0]             x1,
   input  logic [YW-1:0]             y0,
   input  logic [YW-1:0]             y1,
   input  logic [3*CHANNEL_BITS-1:0] wdata,
   input  logic                      wr_ok,
   output logic [3*CHANNEL_BITS-1:0] c00,
   output logic [3*CHANNEL_BITS-1:0] c01,
   output logic [3*CHANNEL_BITS-1:0] c10,
   output logic [3*CHANNEL_BITS-1:0] c11
);
   import bts_pkg::*;

   localparam int HALF_W = (MAX_WIDTH + 1) / 2;
   localparam int HALF_H = (MAX_HEIGHT + 1) / 2;
   localparam int DEPTH  = HALF_W * HALF_H;
   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int DW     = 3 * CHANNEL_BITS;

   logic [DW-1:0] rd_ff [4];
   logic xs0_ff, xs1_ff, ys0_ff, ys1_ff;

   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic [DW-1:0] mem [DEPTH];
      logic [XW-1:0] col;
      logic [YW-1:0] rw;
      logic [AW-1:0] addr;
      logic          we;

      always_comb begin
         col  = (x0[0] == 1'(b % 2)) ? x0 : x1;
         rw   = (y0[0] == 1'(b / 2)) ? y0 : y1;
         addr = AW'(32'(rw >> 1) * HALF_W + 32'(col >> 1));
         we   = wr_ok && (x0[0] == 1'(b % 2)) && (y0[0] == 1'(b / 2));
      end

      always_ff @(posedge clock) begin
         if (we) begin
            mem[addr] <= wdata;
         end
         rd_ff[b] <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      xs0_ff <= x0[0];
      xs1_ff <= x1[0];
      ys0_ff <= y0[0];
      ys1_ff <= y1[0];
   end

   assign c00 = rd_ff[{ys0_ff, xs0_ff}];
   assign c01 = rd_ff[{ys0_ff, xs1_ff}];
   assign c10 = rd_ff[{ys1_ff, xs0_ff}];
   assign c11 = rd_ff[{ys1_ff, xs1_ff}];

endmodule

// ----- design/bts_blend.sv -----
// Weight, multiply and round-and-saturate stages of the bilinear blend; result register.
module bts_blend #(
   parameter int CHANNEL_BITS    = 16,
   parameter int COORD_FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bts_pkg::ctl_type              ctl,
   input  logic [COORD_FRAC_BITS:0]      fx,
   input  logic [COORD_FRAC_BITS:0]      fy,
   input  logic [3*CHANNEL_BITS-1:0]     c00,
   input  logic [3*CHANNEL_BITS-1:0]     c01,
   input  logic [3*CHANNEL_BITS-1:0]     c10,
   input  logic [3*CHANNEL_BITS-1:0]     c11,
   output logic                          strobe,
   output logic [bts_pkg::PORT_CH-1:0]   red_out,
   output logic [bts_pkg::PORT_CH-1:0]   green_out,
   output logic [bts_pkg::PORT_CH-1:0]   blue_out,
   output logic                          is_sample
);
   import bts_pkg::*;

   localparam int F  = COORD_FRAC_BITS;
   localparam int CB = CHANNEL_BITS;
   localparam int WW = 2 * F + 2;
   localparam int PB = CB + WW;
   localparam int SB = PB + 2;
   localparam logic [F:0]      ONE    = (F+1)'(1) << F;
   localparam logic [SB-1:0]   HALF   = SB'(1) << (2 * F - 1);
   localparam logic [CB-1:0]   CH_MAX = '1;

   ctl_type       ctl3_ff, ctl4_ff;
   logic [WW-1:0] w_ff [4];
   logic [WW-1:0] w_in [4];
   logic [PB-1:0] prod_ff [3][4];
   logic [CB-1:0] near_ff [3];
   logic [CB-1:0] tx [4][3];

   logic                strobe_ff, smp_ff;
   logic [PORT_CH-1:0]  out_ff [3];
   logic [PORT_CH-1:0]  out_in [3];

   always_comb begin
      w_in[0] = WW'(ONE - fx) * WW'(ONE - fy);
      w_in[1] = WW'(fx) * WW'(ONE - fy);
      w_in[2] = WW'(ONE - fx) * WW'(fy);
      w_in[3] = WW'(fx) * WW'(fy);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl3_ff <= '0;
      end else begin
         ctl3_ff <= ctl;
      end
      for (int k = 0; k < 4; k++) begin
         w_ff[k] <= w_in[k];
      end
   end

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         tx[0][ch] = c00[ch*CB +: CB];
         tx[1][ch] = c01[ch*CB +: CB];
         tx[2][ch] = c10[ch*CB +: CB];
         tx[3][ch] = c11[ch*CB +: CB];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl4_ff <= '0;
      end else begin
         ctl4_ff <= ctl3_ff;
      end
      for (int ch = 0; ch < 3; ch++) begin
         near_ff[ch] <= tx[0][ch];
         for (int k = 0; k < 4; k++) begin
            prod_ff[ch][k] <= PB'(tx[k][ch]) * PB'(w_ff[k]);
         end
      end
   end

   always_comb begin
      logic [SB-1:0] sum;
      logic [SB-1:0] sh;
      logic [CB-1:0] v;
      for (int ch = 0; ch < 3; ch++) begin
         sum = SB'(prod_ff[ch][0]) + SB'(prod_ff[ch][1]) + SB'(prod_ff[ch][2])
               + SB'(prod_ff[ch][3]) + HALF;
         sh  = sum >> (2 * F);
         if (ctl4_ff.filt) begin
            v = (sh > SB'(CH_MAX)) ? CH_MAX : CB'(sh);
         end else begin
            v = near_ff[ch];
         end
         out_in[ch] = ctl4_ff.sample ? PORT_CH'(v) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= ctl4_ff.valid;
      end
      smp_ff <= ctl4_ff.sample;
      for (int ch = 0; ch < 3; ch++) begin
         out_ff[ch] <= out_in[ch];
      end
   end

   assign strobe    = strobe_ff;
   assign is_sample = smp_ff;
   assign red_out   = out_ff[0];
   assign green_out = out_ff[1];
   assign blue_out  = out_ff[2];

endmodule

// ----- design/bilinear_texture_sampler_core.sv -----
// Top level of the bilinear texture sampler: size registers and pipeline wiring.
//
//  channel  ports                          handshake
//  request  start, busy, req_*             beat taken when start && !busy
//  result   rsp_strobe, rsp_*              one cycle per beat, no back-pressure
//  config   csr_we, csr_index, csr_wdata   written when csr_we
//
// One beat per cycle, every cycle; busy is always low. The result strobe rises after the
// request edge through the input register, coordinate map, bank read, multiply and round.
// The four parity banks give the four neighbours in a single read; a write
// lands in its bank after the input and coordinate registers, so a later sample sees it.
// Synchronous reset clears control state and sets both sizes to 256; store contents
// stay undefined until written.
module bilinear_texture_sampler_core #(
   parameter int MAX_WIDTH       = bts_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT      = bts_pkg::DEF_MAX_HEIGHT,
   parameter int CHANNEL_BITS    = bts_pkg::DEF_CHANNEL_BITS,
   parameter int COORD_FRAC_BITS = bts_pkg::DEF_COORD_FRAC_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_func,
   input  logic [bts_pkg::POS_BITS-1:0]     req_column,
   input  logic [bts_pkg::POS_BITS-1:0]     req_row,
   input  logic [bts_pkg::PORT_CH-1:0]      req_red_in,
   input  logic [bts_pkg::PORT_CH-1:0]      req_green_in,
   input  logic [bts_pkg::PORT_CH-1:0]      req_blue_in,
   input  logic [bts_pkg::COORD_BITS-1:0]   req_coord_s,
   input  logic [bts_pkg::COORD_BITS-1:0]   req_coord_t,
   input  logic                             req_filtered,
   output logic                             rsp_strobe,
   output logic [bts_pkg::PORT_CH-1:0]      rsp_red_out,
   output logic [bts_pkg::PORT_CH-1:0]      rsp_green_out,
   output logic [bts_pkg::PORT_CH-1:0]      rsp_blue_out,
   output logic                             rsp_is_sample,
   input  logic                             csr_we,
   input  logic                             csr_index,
   input  logic [bts_pkg::SIZE_BITS-1:0]    csr_wdata
);
   import bts_pkg::*;

   localparam int XW = $clog2(MAX_WIDTH);
   localparam int YW = $clog2(MAX_HEIGHT);
   localparam int DW = 3 * CHANNEL_BITS;

   logic [SIZE_BITS-1:0] tex_width_ff, tex_width_in;
   logic [SIZE_BITS-1:0] tex_height_ff, tex_height_in;

   ctl_type                ctl2;
   logic [XW-1:0]          x0, x1;
   logic [YW-1:0]          y0, y1;
   logic [COORD_FRAC_BITS:0] fx, fy;
   logic [DW-1:0]          wdata, c00, c01, c10, c11;
   logic                   wr_ok;

   always_comb begin
      tex_width_in  = tex_width_ff;
      tex_height_in = tex_height_ff;
      if (csr_we) begin
         case (csr_reg_type'(csr_index))
            REG_TEX_WIDTH: begin
               tex_width_in = csr_wdata;
            end
            REG_TEX_HEIGHT: begin
               tex_height_in = csr_wdata;
            end
            default: begin
               tex_width_in = tex_width_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tex_width_ff  <= SIZE_RESET;
         tex_height_ff <= SIZE_RESET;
      end else begin
         tex_width_ff  <= tex_width_in;
         tex_height_ff <= tex_height_in;
      end
   end

   assign busy = 1'b0;

   bts_coord #(
      .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
      .CHANNEL_BITS(CHANNEL_BITS), .COORD_FRAC_BITS(COORD_FRAC_BITS)
   ) u_coord (
      .clock(clock), .reset(reset), .start(start), .func(req_func),
      .column(req_column), .row(req_row),
      .red_in(req_red_in), .green_in(req_green_in), .blue_in(req_blue_in),
      .coord_s(req_coord_s), .coord_t(req_coord_t), .filtered(req_filtered),
      .tex_width(tex_width_ff), .tex_height(tex_height_ff),
      .ctl(ctl2), .x0(x0), .x1(x1), .y0(y0), .y1(y1), .fx(fx), .fy(fy),
      .wdata(wdata), .wr_ok(wr_ok)
   );

   bts_texmem #(
      .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .CHANNEL_BITS(CHANNEL_BITS)
   ) u_texmem (
      .clock(clock), .x0(x0), .x1(x1), .y0(y0), .y1(y1),
      .wdata(wdata), .wr_ok(wr_ok),
      .c00(c00), .c01(c01), .c10(c10), .c11(c11)
   );

   bts_blend #(
      .CHANNEL_BITS(CHANNEL_BITS), .COORD_FRAC_BITS(COORD_FRAC_BITS)
   ) u_blend (
      .clock(clock), .reset(reset), .ctl(ctl2), .fx(fx), .fy(fy),
      .c00(c00), .c01(c01), .c10(c10), .c11(c11),
      .strobe(rsp_strobe), .red_out(rsp_red_out), .green_out(rsp_green_out),
      .blue_out(rsp_blue_out), .is_sample(rsp_is_sample)
   );

endmodule

// ----- sim/bilinear_texture_sampler_core_tb.sv -----
// Self-checking testbench for bilinear_texture_sampler_core: texel writes and samples.
`timescale 1ns / 1ps
module bilinear_texture_sampler_core_tb;
   import bts_pkg::*;

   typedef struct {
      func_type    func;
      logic [7:0]  column;
      logic [7:0]  row;
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic [16:0] coord_s;
      logic [16:0] coord_t;
      logic        filtered;
   } texel_op_type;

   typedef struct {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic        is_sample;
   } texel_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_func = 1'b0;
   logic [7:0]  req_column = '0;
   logic [7:0]  req_row = '0;
   logic [15:0] req_red_in = '0;
   logic [15:0] req_green_in = '0;
   logic [15:0] req_blue_in = '0;
   logic [16:0] req_coord_s = '0;
   logic [16:0] req_coord_t = '0;
   logic        req_filtered = 1'b0;
   logic        rsp_strobe;
   logic [15:0] rsp_red_out;
   logic [15:0] rsp_green_out;
   logic [15:0] rsp_blue_out;
   logic        rsp_is_sample;
   logic        csr_we = 1'b0;
   logic        csr_index = 1'b0;
   logic [8:0]  csr_wdata = '0;

   texel_op_type  pending_ops[$];
   texel_rsp_type expected_rsps[$];
   texel_op_type  drive_op;
   logic [47:0] texels [65536];
   bit          gen_written [65536];
   logic [8:0]  model_width = 9'd256;
   logic [8:0]  model_height = 9'd256;
   logic [8:0]  gen_width = 9'd256;
   logic [8:0]  gen_height = 9'd256;
   int          idle_pct = 0;
   int          mismatches = 0;

   bilinear_texture_sampler_core dut (.*);

   always #2 clock = ~clock;

   function automatic int eff_dim(logic [8:0] r);
      if (r == 0) return 1;
      if (r > 256) return 256;
      return int'(r);
   endfunction

   // index and fraction of a coordinate for a given size
   function automatic void map_coord(logic [16:0] c, int size, output int idx,
                                     output longint frac);
      longint p;
      longint cc;
      cc = (c > 17'd65536) ? 65536 : longint'(c);
      p = cc * size;
      idx = int'(p >> 16);
      if (idx >= size) idx = size - 1;
      frac = p - (longint'(idx) << 16);
   endfunction

   function automatic texel_rsp_type sample_texels(logic [16:0] s, logic [16:0] t,
                                                   logic filt);
      texel_rsp_type r;
      int w, h, x, y, x1, y1;
      longint fx, fy;
      logic [63:0] wt [4];
      logic [63:0] acc;
      logic [47:0] c [4];
      w = eff_dim(model_width);
      h = eff_dim(model_height);
      map_coord(s, w, x, fx);
      map_coord(t, h, y, fy);
      x1 = (x + 1 < w) ? x + 1 : w - 1;
      y1 = (y + 1 < h) ? y + 1 : h - 1;
      c[0] = texels[y * 256 + x];
      c[1] = texels[y * 256 + x1];
      c[2] = texels[y1 * 256 + x];
      c[3] = texels[y1 * 256 + x1];
      wt[0] = (65536 - fx) * (65536 - fy);
      wt[1] = fx * (65536 - fy);
      wt[2] = (65536 - fx) * fy;
      wt[3] = fx * fy;
      r.is_sample = 1'b1;
      for (int k = 0; k < 3; k++) begin
         logic [15:0] v;
         if (!filt) begin
            v = c[0][16*k +: 16];
         end else begin
            acc = 64'd1 << 31;
            for (int i = 0; i < 4; i++) acc += 64'(c[i][16*k +: 16]) * wt[i];
            acc = acc >> 32;
            v = (acc > 65535) ? 16'hFFFF : acc[15:0];
         end
         if (k == 0) r.blue = v;
         else if (k == 1) r.green = v;
         else r.red = v;
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   // driver
   always @(posedge clock) begin
      texel_rsp_type exp_rsp;
      logic          next_start;
      if (!reset && start && !busy) begin
         if (drive_op.func == FUNC_WRITE) begin
            texels[{drive_op.row, drive_op.column}] =
               {drive_op.red, drive_op.green, drive_op.blue};
            exp_rsp = '{16'd0, 16'd0, 16'd0, 1'b0};
         end else begin
            exp_rsp = sample_texels(drive_op.coord_s, drive_op.coord_t, drive_op.filtered);
         end
         expected_rsps = {expected_rsps, exp_rsp};
      end
      next_start = start && busy;
      if (!reset && !(start && busy) && pending_ops.size() > 0
          && $urandom_range(99) >= idle_pct) begin
         drive_op = pending_ops.pop_front();
         next_start = 1'b1;
         req_func     <= drive_op.func;
         req_column   <= drive_op.column;
         req_row      <= drive_op.row;
         req_red_in   <= drive_op.red;
         req_green_in <= drive_op.green;
         req_blue_in  <= drive_op.blue;
         req_coord_s  <= drive_op.coord_s;
         req_coord_t  <= drive_op.coord_t;
         req_filtered <= drive_op.filtered;
      end
      start <= next_start;
   end

   // monitor
   always @(posedge clock) begin
      texel_rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_rsps.size() == 0) begin
            $display("unexpected result beat at %0t", $realtime);
            mismatches++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_red_out !== want.red) report_mismatch("red", rsp_red_out, want.red);
            if (rsp_green_out !== want.green)
               report_mismatch("green", rsp_green_out, want.green);
            if (rsp_blue_out !== want.blue) report_mismatch("blue", rsp_blue_out, want.blue);
            if (rsp_is_sample !== want.is_sample)
               report_mismatch("is_sample", 16'(rsp_is_sample), 16'(want.is_sample));
         end
      end
   end

   task automatic add_write(logic [7:0] col, logic [7:0] row, logic [15:0] r,
                            logic [15:0] g, logic [15:0] b);
      texel_op_type op;
      op.func = FUNC_WRITE;
      op.column = col;
      op.row = row;
      op.red = r;
      op.green = g;
      op.blue = b;
      op.coord_s = 17'($urandom);
      op.coord_t = 17'($urandom);
      op.filtered = 1'($urandom);
      gen_written[{row, col}] = 1'b1;
      pending_ops = {pending_ops, op};
   endtask

   // any neighbour not yet written gets a write first
   task automatic add_sample(logic [16:0] s, logic [16:0] t, logic filt);
      texel_op_type op;
      int x, y, x1, y1, w, h;
      longint fx, fy;
      int xs [2];
      int ys [2];
      w = eff_dim(gen_width);
      h = eff_dim(gen_height);
      map_coord(s, w, x, fx);
      map_coord(t, h, y, fy);
      xs[0] = x;
      xs[1] = (x + 1 < w) ? x + 1 : w - 1;
      ys[0] = y;
      ys[1] = (y + 1 < h) ? y + 1 : h - 1;
      foreach (ys[j])
         foreach (xs[i])
            if (!gen_written[ys[j] * 256 + xs[i]])
               add_write(8'(xs[i]), 8'(ys[j]), 16'($urandom), 16'($urandom),
                         16'($urandom));
      op.func = FUNC_SAMPLE;
      op.column = 8'($urandom);
      op.row = 8'($urandom);
      op.red = 16'($urandom);
      op.green = 16'($urandom);
      op.blue = 16'($urandom);
      op.coord_s = s;
      op.coord_t = t;
      op.filtered = filt;
      pending_ops = {pending_ops, op};
   endtask

   task automatic drain();
      do @(negedge clock);
      while (pending_ops.size() != 0 || start || expected_rsps.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_size(csr_reg_type idx, logic [8:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == REG_TEX_WIDTH) begin
         model_width = value;
         gen_width = value;
      end else begin
         model_height = value;
         gen_height = value;
      end
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [16:0] rand_coord();
      int sel;
      sel = $urandom_range(9);
      if (sel == 0) return 17'd65536;
      if (sel == 1) return 17'($urandom);
      if (sel == 2) return 17'd0;
      return 17'($urandom_range(65535));
   endfunction

   initial begin
      logic [8:0] widths [8] = '{9'd1, 9'd256, 9'd0, 9'd2, 9'd7, 9'd300, 9'd16, 9'd511};
      logic [8:0] heights [8] = '{9'd1, 9'd256, 9'd511, 9'd3, 9'd5, 9'd1, 9'd16, 9'd0};
      int pcts [4] = '{0, 47, 28, 0};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: edge channels and positions, coordinates 0 to 1.0 and above
      add_write(8'd0, 8'd0, 16'hFFFF, 16'h0000, 16'hFFFF);
      add_write(8'd255, 8'd255, 16'h0000, 16'hFFFF, 16'h0000);
      add_write(8'd255, 8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      add_write(8'd0, 8'd255, 16'h0001, 16'h8000, 16'h7FFF);
      add_sample(17'd0, 17'd0, 1'b0);
      add_sample(17'd0, 17'd0, 1'b1);
      add_sample(17'd65536, 17'd65536, 1'b0);
      add_sample(17'd65536, 17'd65536, 1'b1);
      add_sample(17'h1FFFF, 17'h1FFFF, 1'b1);
      add_sample(17'h1FFFF, 17'd0, 1'b0);
      add_sample(17'd65535, 17'd65535, 1'b1);
      add_sample(17'd32768, 17'd32768, 1'b1);
      add_sample(17'd65535, 17'd256, 1'b1);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         write_size(REG_TEX_WIDTH, widths[ph]);
         write_size(REG_TEX_HEIGHT, heights[ph]);
         idle_pct = pcts[ph % 4];
         for (int n = 0; n < 35; n++) begin
            if ($urandom_range(9) < 3)
               add_write(8'($urandom_range(eff_dim(gen_width) - 1)),
                         8'($urandom_range(eff_dim(gen_height) - 1)),
                         16'($urandom), 16'($urandom), 16'($urandom));
            else
               add_sample(rand_coord(), rand_coord(), 1'($urandom));
         end
         drain();
      end

      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #4ms;
      $display("status: fail");
      $finish;
   end
endmodule

// ----- files.f -----
design/bts_pkg.sv
design/bts_coord.sv
design/bts_texmem.sv
design/bts_blend.sv
design/bilinear_texture_sampler_core.sv
sim/bilinear_texture_sampler_core_tb.sv
